>>> src/etic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time iteration counter package
// Shared widths, the slot record that circulates through the iteration ring,
// and the saturation helper.
// ----------------------------------------------------------------------------
package etic_pkg;

  localparam int FRAC_BITS = 28;
  localparam int C_W       = 31;
  localparam int Z_W       = 32;
  localparam int CNT_W     = 16;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;
  localparam int NUM_SLOTS = 3;
  localparam int PH_W      = 2;

  // Squared magnitude at or above this value means the point escaped (four).
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(64'd4 << (2 * FRAC_BITS));

  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  // One point in flight: occupancy, completion, the constant c and the count.
  typedef struct packed {
    logic                    valid;
    logic                    done;
    logic signed [C_W-1:0]   c_re;
    logic signed [C_W-1:0]   c_im;
    logic [CNT_W-1:0]        count;
  } slot_t;

  // Saturate a wide signed sum to the signed state range.
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v > SUM_W'(Z_MAX)) begin
      r = Z_MAX;
    end else if (v < SUM_W'(Z_MIN)) begin
      r = Z_MIN;
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/etic_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time iteration counter: product stage
// Forms the exact products x*x, y*y and x*y of the working point.
// ----------------------------------------------------------------------------
module etic_square (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  etic_pkg::slot_t                          slot_i,
  input  logic signed [etic_pkg::Z_W-1:0]          z_re_i,
  input  logic signed [etic_pkg::Z_W-1:0]          z_im_i,
  output etic_pkg::slot_t                          slot_o,
  output logic signed [etic_pkg::PROD_W-1:0]       xx_o,
  output logic signed [etic_pkg::PROD_W-1:0]       yy_o,
  output logic signed [etic_pkg::PROD_W-1:0]       xy_o
);

  etic_pkg::slot_t slot_q;
  logic signed [etic_pkg::PROD_W-1:0] xx_q, yy_q, xy_q;

  // The slot record moves on every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_i;
    end
  end

  // Three exact 32 x 32 products.
  always_ff @(posedge clk_i) begin
    xx_q <= etic_pkg::PROD_W'(z_re_i) * etic_pkg::PROD_W'(z_re_i);
    yy_q <= etic_pkg::PROD_W'(z_im_i) * etic_pkg::PROD_W'(z_im_i);
    xy_q <= etic_pkg::PROD_W'(z_re_i) * etic_pkg::PROD_W'(z_im_i);
  end

  assign slot_o = slot_q;
  assign xx_o   = xx_q;
  assign yy_o   = yy_q;
  assign xy_o   = xy_q;

endmodule

>>> src/etic_escape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time iteration counter: escape test stage
// Compares the squared magnitude against four and scales the new z terms.
// ----------------------------------------------------------------------------
module etic_escape (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  etic_pkg::slot_t                          slot_i,
  input  logic signed [etic_pkg::PROD_W-1:0]       xx_i,
  input  logic signed [etic_pkg::PROD_W-1:0]       yy_i,
  input  logic signed [etic_pkg::PROD_W-1:0]       xy_i,
  output etic_pkg::slot_t                          slot_o,
  output logic                                     escape_o,
  output logic signed [etic_pkg::PROD_W-1:0]       re_sh_o,
  output logic signed [etic_pkg::PROD_W-1:0]       im_sh_o
);

  etic_pkg::slot_t slot_q;
  logic escape_q;
  logic signed [etic_pkg::PROD_W-1:0] re_sh_q, im_sh_q;
  logic [etic_pkg::PROD_W-1:0] mag;
  logic signed [etic_pkg::PROD_W-1:0] diff;

  // Both squares are non-negative and at most 2^62, so neither sum nor
  // difference overflows 64 bits.
  assign mag  = xx_i + yy_i;
  assign diff = xx_i - yy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_i;
    end
  end

  // Arithmetic shifts round toward minus infinity; 2xy uses one less shift.
  always_ff @(posedge clk_i) begin
    escape_q <= (mag >= etic_pkg::ESC_LIMIT);
    re_sh_q  <= diff >>> etic_pkg::FRAC_BITS;
    im_sh_q  <= xy_i >>> (etic_pkg::FRAC_BITS - 1);
  end

  assign slot_o   = slot_q;
  assign escape_o = escape_q;
  assign re_sh_o  = re_sh_q;
  assign im_sh_o  = im_sh_q;

endmodule

>>> src/escape_time_iteration_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time iteration counter
// Counts Mandelbrot iterations of a Q3.28 point until escape or the limit.
// ----------------------------------------------------------------------------
// Each iteration of a point passes once around the iteration loop, a ring of
// three register stages (products, escape test, update). Three points share
// the ring, one per slot. Results leave in input order; a finished point
// waits in its slot until its elder points have left.
module escape_time_iteration_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // max_iterations
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,     // c_real [30:0], c_imag [61:31], zero [63:62]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,     // iteration_count [15:0]
  output logic        m_axis_tuser      // stayed_inside [0]
);

  localparam int CW = etic_pkg::C_W;
  localparam int ZW = etic_pkg::Z_W;
  localparam int NW = etic_pkg::CNT_W;
  localparam int PW = etic_pkg::PROD_W;
  localparam int SW = etic_pkg::SUM_W;
  localparam int HW = etic_pkg::PH_W;

  logic [NW-1:0] max_iter_q;
  logic [HW-1:0] ph_q, rp_q, wp_q;
  etic_pkg::slot_t slot1_q, slot1_d, slot2, slot3, nxt;
  logic signed [ZW-1:0] z_re_q, z_im_q, z_re_d, z_im_d, upd_re, upd_im;
  logic signed [PW-1:0] xx, yy, xy, re_sh, im_sh;
  logic escape;
  logic out_valid_q, out_inside_q, out_free, retire, load;
  logic [NW-1:0] out_count_q;
  logic signed [CW-1:0] in_re, in_im;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= NW'(50);
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  etic_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .slot_i (slot1_q),
    .z_re_i (z_re_q),
    .z_im_i (z_im_q),
    .slot_o (slot2),
    .xx_o   (xx),
    .yy_o   (yy),
    .xy_o   (xy)
  );

  etic_escape u_escape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slot_i   (slot2),
    .xx_i     (xx),
    .yy_i     (yy),
    .xy_i     (xy),
    .slot_o   (slot3),
    .escape_o (escape),
    .re_sh_o  (re_sh),
    .im_sh_o  (im_sh)
  );

  // New z from the scaled terms plus c, saturated.
  assign upd_re = etic_pkg::sat_z(SW'(re_sh) + SW'(slot3.c_re));
  assign upd_im = etic_pkg::sat_z(SW'(im_sh) + SW'(slot3.c_im));

  // Update stage: the limit is checked before the escape test.
  always_comb begin
    nxt    = slot3;
    z_re_d = upd_re;
    z_im_d = upd_im;
    if (slot3.valid && !slot3.done) begin
      if (slot3.count >= max_iter_q || escape) begin
        nxt.done = 1'b1;
      end else begin
        nxt.count = slot3.count + NW'(1);
      end
    end
  end

  // Retire the oldest point when done; load a new point into a free slot.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign retire        = nxt.valid && nxt.done && (ph_q == rp_q) && out_free;
  assign s_axis_tready = (ph_q == wp_q) && (!nxt.valid || retire);
  assign load          = s_axis_tvalid && s_axis_tready;
  assign in_re         = s_axis_tdata[CW-1:0];
  assign in_im         = s_axis_tdata[2*CW-1:CW];

  always_comb begin
    slot1_d = nxt;
    if (retire) begin
      slot1_d.valid = 1'b0;
    end
    if (load) begin
      slot1_d.valid = 1'b1;
      slot1_d.done  = 1'b0;
      slot1_d.c_re  = in_re;
      slot1_d.c_im  = in_im;
      slot1_d.count = '0;
    end
  end

  // Ring head register and slot pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot1_q <= '0;
      ph_q    <= '0;
      rp_q    <= '0;
      wp_q    <= '0;
    end else begin
      slot1_q <= slot1_d;
      ph_q    <= (ph_q == HW'(etic_pkg::NUM_SLOTS - 1)) ? '0 : ph_q + HW'(1);
      if (retire) begin
        rp_q <= (rp_q == HW'(etic_pkg::NUM_SLOTS - 1)) ? '0 : rp_q + HW'(1);
      end
      if (load) begin
        wp_q <= (wp_q == HW'(etic_pkg::NUM_SLOTS - 1)) ? '0 : wp_q + HW'(1);
      end
    end
  end

  // Working point, loaded with c on entry.
  always_ff @(posedge clk_i) begin
    if (load) begin
      z_re_q <= ZW'(in_re);
      z_im_q <= ZW'(in_im);
    end else begin
      z_re_q <= z_re_d;
      z_im_q <= z_im_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (retire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_count_q  <= nxt.count;
      out_inside_q <= (nxt.count == max_iter_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_inside_q;

`ifndef ASSERT_OFF
  // A loaded point starts fresh at the head of the ring.
  a_load_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> slot1_q.valid && !slot1_q.done && slot1_q.count == '0)
    else $error("loaded slot not initialized");

  // The phase counter wraps after the last slot.
  a_phase_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == HW'(etic_pkg::NUM_SLOTS - 1) |=> ph_q == '0)
    else $error("phase counter did not wrap");

  // A retired count never exceeds the limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |-> nxt.count <= max_iter_q)
    else $error("count exceeds limit");
`endif

endmodule

>>> test/tb_escape_time_iteration_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time iteration counter testbench
// Streams complex points into the counter and checks each returned count and
// inside flag against a bit-exact escape-time predictor kept in the bench.
// Several iteration limits are applied, among them zero, one and the largest.
// ----------------------------------------------------------------------------
module tb_escape_time_iteration_counter_unit;

  localparam int  C_W            = etic_pkg::C_W;
  localparam int  CNT_W          = etic_pkg::CNT_W;
  localparam int  FRAC_BITS      = etic_pkg::FRAC_BITS;
  localparam int  WATCHDOG_LIMIT = 2_000_000;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  HOLD_AT_ITEM   = 420;
  localparam logic signed [C_W-1:0] ONE_Q = 31'sd268435456;   // 1.0
  localparam logic signed [C_W-1:0] TWO_Q = 31'sd536870912;   // 2.0

  typedef struct {
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
  } point_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             stayed;
  } escape_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  point_t      pending_points[$];
  escape_t     expected_escapes[$];
  logic [15:0] iter_limit;
  int          errors;
  int          points_sent;
  int          tx_gap;
  int          rx_gap;
  int          hold_left;
  bit          hold_done;
  bit          calm;
  int          quiet_cycles;

  escape_time_iteration_counter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Saturate a wide value to the signed 32-bit working range.
  function automatic longint clamp_state(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Iterate z = z^2 + c from z = c and count steps with |z|^2 below four.
  function automatic escape_t escape_count(input logic signed [C_W-1:0] cr,
                                           input logic signed [C_W-1:0] ci,
                                           input logic [CNT_W-1:0] limit);
    longint           x, y, x2, y2, xy, cre, cim;
    logic [63:0]      mag;
    logic [CNT_W-1:0] n;
    escape_t          r;
    cre = cr;
    cim = ci;
    x = cre;
    y = cim;
    n = '0;
    while (n < limit) begin
      x2  = x * x;
      y2  = y * y;
      xy  = x * y;
      mag = x2 + y2;
      // (mag >> 28) >= 4 << 28 is the same as mag >= 2^58.
      if (mag >= (64'd1 << 58)) break;
      n = n + 1'b1;
      x = clamp_state(((x2 - y2) >>> FRAC_BITS) + cre);
      y = clamp_state((xy >>> (FRAC_BITS - 1)) + cim);
    end
    r.count  = n;
    r.stayed = (n == limit);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_point(input logic signed [C_W-1:0] re,
                           input logic signed [C_W-1:0] im);
    point_t p;
    p.c_re = re;
    p.c_im = im;
    pending_points.push_back(p);
  endtask

  // Random points: mostly within the square |re|, |im| <= 2, some near the set
  // boundary, some anywhere in the 31-bit range.
  task automatic add_random(input int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        add_point(C_W'($urandom), C_W'($urandom));
      end else if (kind < 6) begin
        add_point(C_W'(int'($urandom_range(0, 2 * TWO_Q)) - TWO_Q),
                  C_W'(int'($urandom_range(0, 2 * TWO_Q)) - TWO_Q));
      end else if (kind < 9) begin
        add_point(C_W'(int'($urandom_range(0, TWO_Q + ONE_Q / 4)) - TWO_Q),
                  C_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q));
      end else begin
        add_point($urandom_range(0, 1) ? TWO_Q : -TWO_Q,
                  C_W'(int'($urandom_range(0, 2 * TWO_Q)) - TWO_Q));
      end
    end
  endtask

  // Wait until every queued point has been sent and every result checked.
  task automatic wait_drained();
    while (pending_points.size() != 0 || expected_escapes.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    iter_limit  = value;
    @(posedge clk_i);
  endtask

  // Driver: offers queued points and records the expected result on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap        <= 0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        expected_escapes.push_back(escape_count(pending_points[0].c_re,
                                                pending_points[0].c_im, iter_limit));
        void'(pending_points.pop_front());
        points_sent++;
      end
      if (s_axis_tvalid && !fire) begin
        // Hold the current transaction until it is taken.
      end else if (tx_gap > 0) begin
        tx_gap        <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        tx_gap        <= $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pending_points[0].c_im, pending_points[0].c_re};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering points.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && points_sent >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transaction and drives tready.
  always @(posedge clk_i or negedge rst_ni) begin
    escape_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_escapes.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, -1);
        end else begin
          want = expected_escapes.pop_front();
          if (m_axis_tdata !== want.count) begin
            report_mismatch("iteration_count", m_axis_tdata, want.count);
          end
          if (m_axis_tuser !== want.stayed) begin
            report_mismatch("stayed_inside", m_axis_tuser, want.stayed);
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap        <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap        <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    errors       = 0;
    points_sent  = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    iter_limit   = 16'd50;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset limit: extremes, origin, known orbits.
    add_point('0, '0);
    add_point({1'b1, {(C_W-1){1'b0}}}, {1'b1, {(C_W-1){1'b0}}});
    add_point({1'b0, {(C_W-1){1'b1}}}, {1'b0, {(C_W-1){1'b1}}});
    add_point({1'b0, {(C_W-1){1'b1}}}, {1'b1, {(C_W-1){1'b0}}});
    add_point(TWO_Q, '0);
    add_point(-TWO_Q, '0);
    add_point('0, TWO_Q);
    add_point('0, -TWO_Q);
    add_point(TWO_Q, TWO_Q);
    add_point(-TWO_Q, -TWO_Q);
    add_point(-ONE_Q, '0);
    add_point(ONE_Q / 4, '0);
    add_point(ONE_Q / 4 + 1, '0);
    add_point('0, ONE_Q);
    add_point(-TWO_Q + 1, '0);
    add_point(-ONE_Q / 2, ONE_Q / 2);
    add_point(ONE_Q, ONE_Q);
    add_point(-31'sd1, -31'sd1);
    add_point(31'sd1, '0);
    add_point(-ONE_Q * 3 / 4, ONE_Q / 8);
    add_random(200);

    write_limit(16'd1);
    add_random(100);
    write_limit(16'd0);
    add_point('0, '0);
    add_point({1'b0, {(C_W-1){1'b1}}}, '0);
    add_random(60);
    write_limit(16'd16);
    add_random(300);
    write_limit(16'hFFFF);
    add_point('0, '0);
    add_point(-ONE_Q, '0);
    add_point(TWO_Q, ONE_Q);
    add_point(ONE_Q / 4 + 4096, '0);
    write_limit(16'd7);
    add_random(200);
    write_limit(16'd100);
    add_random(150);
    write_limit(16'd255);
    add_random(60);
    write_limit(16'd30);
    calm = 1'b1;
    add_random(280);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
